// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Holds the controller state type, the command and status structs that
// join the controller to the datapath, ASCII codes and the digit lookup.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned ValueW = 64;
  localparam int unsigned FieldW = 6;
  localparam int unsigned CharW  = 8;

  // Width of character counts; the layout sums stay well below 256.
  localparam int unsigned CntW     = 8;
  // At most this many characters leave for one item.
  localparam int unsigned MaxChars = 64;
  localparam int unsigned RemW     = 7;

  // ASCII codes.
  localparam logic [CharW-1:0] AsciiSpace = 8'h20;
  localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiUpA   = 8'h41;
  localparam logic [CharW-1:0] AsciiLowA  = 8'h61;
  localparam logic [CharW-1:0] AsciiNul   = 8'h00;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_PLAN,
    S_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
    logic plan;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic scan_done;
    logic out_free;
    logic last_char;
  } sts_t;

  // One input transaction as the datapath sees it.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_signed;
    logic              base_hex;
    logic              upper_case;
    logic              left_just;
    logic              zero_fill;
    logic [FieldW-1:0] field_width;
    logic              precision_given;
    logic [FieldW-1:0] min_digits;
  } in_item_t;

  // Map one digit nibble to its ASCII character.
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? AsciiUpA : AsciiLowA;
    if (nib < 4'd10) begin
      digit_char = AsciiZero + {4'd0, nib};
    end else begin
      digit_char = base + {4'd0, nib} - 8'd10;
    end
  endfunction

endpackage

// ===== design/i2a_in_if.sv =====
// ----------------------------------------------------------------------------
// i2a_in_if: input channel of the formatter
// Valid/ready channel carrying one value with its conversion settings.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        is_signed;
  logic        base_hex;
  logic        upper_case;
  logic        left_just;
  logic        zero_fill;
  logic [5:0]  field_width;
  logic        precision_given;
  logic [5:0]  min_digits;

  modport source (
    output valid, value, is_signed, base_hex, upper_case, left_just, zero_fill,
           field_width, precision_given, min_digits,
    input  ready
  );
  modport sink (
    input  valid, value, is_signed, base_hex, upper_case, left_just, zero_fill,
           field_width, precision_given, min_digits,
    output ready
  );
endinterface

// ===== design/i2a_out_if.sv =====
// ----------------------------------------------------------------------------
// i2a_out_if: output channel of the formatter
// Valid/ready channel carrying one ASCII character per transaction.
// ----------------------------------------------------------------------------
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic       empty_res;

  modport source (output valid, char_code, last, empty_res, input ready);
  modport sink (input valid, char_code, last, empty_res, output ready);
endinterface

// ===== design/i2a_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2a_ctrl: formatter controller
// Sequences load, binary to digit conversion, leading zero scan, layout
// planning and character emission by commands to the datapath.
// ----------------------------------------------------------------------------
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        if (sts_i.conv_done) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.conv = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_PLAN;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_char) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/i2a_datapath.sv =====
// ----------------------------------------------------------------------------
// i2a_datapath: formatter datapath
// Shift-and-add-3 conversion one bit per cycle (plain shift for hex),
// a nibble-wise leading zero scan, the width/precision layout arithmetic,
// the per-character sequencing counters and the output register.
// ----------------------------------------------------------------------------
module i2a_datapath
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned DIGIT_SLOTS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_item_t         item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o,
  output logic             out_empty_o
);

  localparam int unsigned DigW  = 4 * DIGIT_SLOTS;
  localparam int unsigned BitW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned SlotW = $clog2(DIGIT_SLOTS + 1);

  // Conversion state.
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [DigW-1:0]       dig_q, dig_d;
  logic                  ovf_q, ovf_d;
  logic [BitW-1:0]       bits_q, bits_d;
  logic [SlotW-1:0]      slots_q, slots_d;

  // Settings held for the item.
  logic              neg_q, hex_q, upper_q, left_q, zflag_q, pg_q;
  logic [FieldW-1:0] width_q, prec_q;

  // Emission counters.
  logic [CntW-1:0] pad_q, pad_d;
  logic [CntW-1:0] zeros_q, zeros_d;
  logic [CntW-1:0] len_q, len_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            sign_q, sign_d;
  logic            empty_q, empty_d;

  // Output register.
  logic             ovalid_q, ovalid_d;
  logic [CharW-1:0] ochar_q, ochar_d;
  logic             olast_q, olast_d;
  logic             oempty_q, oempty_d;

  // Load-time negation.
  logic [VALUE_BITS-1:0] load_v;
  logic                  load_neg;
  assign load_v   = item_i.value[VALUE_BITS-1:0];
  assign load_neg = item_i.is_signed && !item_i.base_hex && load_v[VALUE_BITS-1];

  // Add 3 to every digit of 5 or more before the shift (decimal only).
  logic [DigW-1:0] adj;
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (!hex_q && (dig_q[i*4 +: 4] >= 4'd5)) begin
        adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = dig_q[i*4 +: 4];
      end
    end
  end

  // Layout arithmetic for the plan step.
  logic [CntW-1:0] width_c, prec_c, slots_c, len_c, w_c, zeros_c, body_c, pad_c, n_c;
  logic            zp_c;
  always_comb begin
    width_c = {{(CntW-FieldW){1'b0}}, width_q};
    prec_c  = {{(CntW-FieldW){1'b0}}, prec_q};
    slots_c = CntW'(slots_q);
    if (slots_q == '0) begin
      len_c = (pg_q && (prec_q == '0)) ? '0 : CntW'(1);
    end else begin
      len_c = slots_c;
    end
    w_c = width_c - CntW'(neg_q && (width_q != '0));
    zp_c = zflag_q && !left_q && !pg_q;
    zeros_c = '0;
    if (pg_q) begin
      if (prec_c > len_c) begin
        zeros_c = prec_c - len_c;
      end
    end else if (zp_c && (w_c > len_c)) begin
      zeros_c = w_c - len_c;
    end
    body_c = len_c + zeros_c;
    pad_c  = (w_c > body_c) ? (w_c - body_c) : '0;
    n_c    = pad_c + body_c + CntW'(neg_q);
  end

  // Which character goes out next.
  logic             out_free, lead_c, zero_c, digit_c;
  logic [CharW-1:0] char_c;
  always_comb begin
    out_free = !ovalid_q || out_ready_i;
    lead_c   = !left_q && (pad_q != '0);
    zero_c   = zeros_q != '0;
    digit_c  = len_q != '0;
    if (empty_q) begin
      char_c = AsciiNul;
    end else if (lead_c) begin
      char_c = AsciiSpace;
    end else if (sign_q) begin
      char_c = AsciiMinus;
    end else if (zero_c) begin
      char_c = AsciiZero;
    end else if (digit_c) begin
      char_c = digit_char(dig_q[DigW-1 -: 4], upper_q);
    end else begin
      char_c = AsciiSpace;
    end
  end

  // Next-state logic for the datapath registers.
  always_comb begin
    val_d     = val_q;
    dig_d     = dig_q;
    ovf_d     = ovf_q;
    bits_d    = bits_q;
    slots_d   = slots_q;
    pad_d     = pad_q;
    zeros_d   = zeros_q;
    len_d     = len_q;
    rem_d     = rem_q;
    sign_d    = sign_q;
    empty_d   = empty_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ochar_d   = ochar_q;
    olast_d   = olast_q;
    oempty_d  = oempty_q;
    if (cmd_i.load) begin
      val_d   = load_neg ? (~load_v + VALUE_BITS'(1)) : load_v;
      dig_d   = '0;
      ovf_d   = 1'b0;
      bits_d  = BitW'(VALUE_BITS);
      slots_d = SlotW'(DIGIT_SLOTS);
    end
    if (cmd_i.conv) begin
      dig_d  = {adj[DigW-2:0], val_q[VALUE_BITS-1]};
      ovf_d  = ovf_q | adj[DigW-1];
      val_d  = {val_q[VALUE_BITS-2:0], 1'b0};
      bits_d = bits_q - BitW'(1);
    end
    if (cmd_i.scan) begin
      dig_d   = {dig_q[DigW-5:0], 4'd0};
      slots_d = slots_q - SlotW'(1);
    end
    if (cmd_i.plan) begin
      pad_d   = pad_c;
      zeros_d = zeros_c;
      len_d   = len_c;
      sign_d  = neg_q;
      empty_d = n_c == '0;
      rem_d   = (n_c > CntW'(MaxChars)) ? RemW'(MaxChars) : n_c[RemW-1:0];
    end
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
      ochar_d  = char_c;
      olast_d  = rem_q <= RemW'(1);
      oempty_d = empty_q;
      rem_d    = rem_q - RemW'(!empty_q);
      if (lead_c) begin
        pad_d = pad_q - CntW'(1);
      end else if (sign_q) begin
        sign_d = 1'b0;
      end else if (zero_c) begin
        zeros_d = zeros_q - CntW'(1);
      end else if (digit_c) begin
        len_d = len_q - CntW'(1);
        dig_d = {dig_q[DigW-5:0], 4'd0};
      end else begin
        pad_d = pad_q - CntW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    dig_q    <= dig_d;
    ovf_q    <= ovf_d;
    bits_q   <= bits_d;
    slots_q  <= slots_d;
    pad_q    <= pad_d;
    zeros_q  <= zeros_d;
    len_q    <= len_d;
    rem_q    <= rem_d;
    sign_q   <= sign_d;
    empty_q  <= empty_d;
    ochar_q  <= ochar_d;
    olast_q  <= olast_d;
    oempty_q <= oempty_d;
    if (cmd_i.load) begin
      neg_q   <= load_neg;
      hex_q   <= item_i.base_hex;
      upper_q <= item_i.upper_case;
      left_q  <= item_i.left_just;
      zflag_q <= item_i.zero_fill;
      width_q <= item_i.field_width;
      pg_q    <= item_i.precision_given;
      prec_q  <= item_i.min_digits;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o.conv_done = bits_q == '0;
    sts_o.scan_done = (slots_q == '0) || (dig_q[DigW-1 -: 4] != 4'd0) || ovf_q;
    sts_o.out_free  = out_free;
    sts_o.last_char = rem_q <= RemW'(1);
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;
  assign out_empty_o = oempty_q;

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style integer to ASCII conversion
// Formats one value with sign, base, case, width, alignment, zero padding
// and precision settings into a stream of ASCII characters.
//
//   Channel | Direction | Payload                                   | Per transaction
//   in_i    | sink      | value, is_signed, base_hex, upper_case,   | one value
//           |           | left_just, zero_fill, field_width,        |
//           |           | precision_given, min_digits               |
//   out_o   | source    | char_code, last, empty_res                | one character
//
// An item goes through conversion (one bit a cycle through the shift-and-add-3
// register), a leading zero scan, a planning step, then one character per cycle
// while the output register is free to take it (at most 64 characters).
// The next item is taken once the last character sits in the output register.
// Reset clears the controller and the output valid; no memory needs clearing.
// A stalled output holds the character and pauses emission.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned DIGIT_SLOTS = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  i2a_in_if.sink    in_i,
  i2a_out_if.source out_o
);

  cmd_t     cmd;
  sts_t     sts;
  in_item_t item;
  logic     in_ready;

  // Gather the input payload.
  assign item.value           = in_i.value;
  assign item.is_signed       = in_i.is_signed;
  assign item.base_hex        = in_i.base_hex;
  assign item.upper_case      = in_i.upper_case;
  assign item.left_just       = in_i.left_just;
  assign item.zero_fill       = in_i.zero_fill;
  assign item.field_width     = in_i.field_width;
  assign item.precision_given = in_i.precision_given;
  assign item.min_digits      = in_i.min_digits;
  assign in_i.ready           = in_ready;

  // Controller.
  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  i2a_datapath #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.char_code),
    .out_last_o  (out_o.last),
    .out_empty_o (out_o.empty_res)
  );

endmodule
